FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine: request and result
// items, request kinds and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

	localparam logic [1:0] REQ_READ   = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int POS_W = 5;
	localparam int LEN_W = 5;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [POS_W-1:0] position;
		logic signed [31:0] data_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_data;
		logic [1:0]         status;
		logic [LEN_W-1:0]   list_length;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/ple_req_if.sv
// ----------------------------------------------------------------------------
// ple_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_req_if;
	import ple_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ple_rsp_if.sv
// ----------------------------------------------------------------------------
// ple_rsp_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_rsp_if;
	import ple_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH signed 32-bit values addressed by position,
// with read, insert and delete requests.
// ----------------------------------------------------------------------------
// One item is in flight at a time; req.ready is high only while the engine
// is idle. A read goes through a wait state to the result stage; a
// rejected request goes straight to it. Insert and delete time grows with
// the entries moved and is set by the entry store, a single memory with
// one read and one write port: each entry moves one place through a read
// state and then a write state. A finished result waits in the output
// register while the next item is accepted and worked on.
`default_nettype none

module positional_list_engine #(
	parameter int DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ple_req_if.sink    req,
	ple_rsp_if.source  rsp
);
	import ple_pkg::*;

	localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RDWAIT = 3'd1;
	localparam logic [2:0] S_INS_RD = 3'd2;
	localparam logic [2:0] S_INS_WR = 3'd3;
	localparam logic [2:0] S_DEL_RD = 3'd4;
	localparam logic [2:0] S_DEL_WR = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      pos_q;
	logic [1:0]         kind_q;
	logic [1:0]         st_q;
	logic               ins_q;
	logic               del_q;
	logic signed [31:0] data_q;
	logic signed [31:0] rdata_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic signed [31:0] mem [DEPTH];

	logic               accept;
	logic               fin_go;
	logic [CMPW-1:0]    pos_w;
	logic [CMPW-1:0]    cnt_w;
	logic [CMPW-1:0]    ptr_w;
	logic               re;
	logic [AW-1:0]      raddr;
	logic               we;
	logic [AW-1:0]      waddr;
	logic signed [31:0] wdata;
	logic [CW-1:0]      cnt_next;

	assign accept = req.valid && req.ready;
	assign fin_go = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);
	assign pos_w  = CMPW'(req.data.position);
	assign cnt_w  = CMPW'(cnt_q);
	assign ptr_w  = CMPW'(ptr_q);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_comb begin
		re    = 1'b0;
		raddr = ptr_q;
		we    = 1'b0;
		waddr = ptr_q;
		wdata = rdata_q;
		case (state_q)
			S_IDLE: begin
				raddr = AW'(pos_w);
				re    = accept && (req.data.req_type == REQ_READ) && (pos_w < cnt_w);
			end
			S_INS_RD: begin
				if (ptr_q == pos_q) begin
					we    = 1'b1;
					wdata = data_q;
				end else begin
					re    = 1'b1;
					raddr = ptr_q - AW'(1);
				end
			end
			S_INS_WR: begin
				we = 1'b1;
			end
			S_DEL_RD: begin
				re    = (ptr_w + CMPW'(1)) != cnt_w;
				raddr = ptr_q + AW'(1);
			end
			S_DEL_WR: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_comb begin
		cnt_next = cnt_q;
		if (ins_q) begin
			cnt_next = cnt_q + CW'(1);
		end else if (del_q) begin
			cnt_next = cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.data.req_type)
							REQ_READ: begin
								state_q <= (pos_w < cnt_w) ? S_RDWAIT : S_FIN;
							end
							REQ_INSERT: begin
								state_q <= (pos_w > cnt_w || cnt_w >= CMPW'(DEPTH)) ?
									S_FIN : S_INS_RD;
							end
							REQ_DELETE: begin
								state_q <= (cnt_w == '0 || pos_w >= cnt_w) ?
									S_FIN : S_DEL_RD;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_RDWAIT: begin
					state_q <= S_FIN;
				end
				S_INS_RD: begin
					state_q <= (ptr_q == pos_q) ? S_FIN : S_INS_WR;
				end
				S_INS_WR: begin
					state_q <= S_INS_RD;
				end
				S_DEL_RD: begin
					state_q <= ((ptr_w + CMPW'(1)) == cnt_w) ? S_FIN : S_DEL_WR;
				end
				S_DEL_WR: begin
					state_q <= S_DEL_RD;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q     <= S_IDLE;
						cnt_q       <= cnt_next;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q <= req.data.req_type;
					data_q <= req.data.data_in;
					pos_q  <= AW'(pos_w);
					ins_q  <= 1'b0;
					del_q  <= 1'b0;
					st_q   <= ST_OK;
					case (req.data.req_type)
						REQ_READ: begin
							if (pos_w >= cnt_w) begin
								st_q <= ST_RANGE;
							end
						end
						REQ_INSERT: begin
							ptr_q <= AW'(cnt_q);
							if (pos_w > cnt_w) begin
								st_q <= ST_RANGE;
							end else if (cnt_w >= CMPW'(DEPTH)) begin
								st_q <= ST_FULL;
							end else begin
								ins_q <= 1'b1;
							end
						end
						REQ_DELETE: begin
							ptr_q <= AW'(pos_w);
							if (cnt_w != '0) begin
								if (pos_w >= cnt_w) begin
									st_q <= ST_RANGE;
								end else begin
									del_q <= 1'b1;
								end
							end
						end
						default: begin
							st_q <= ST_RANGE;
						end
					endcase
				end
			end
			S_INS_WR: begin
				ptr_q <= ptr_q - AW'(1);
			end
			S_DEL_WR: begin
				ptr_q <= ptr_q + AW'(1);
			end
			S_FIN: begin
				if (fin_go) begin
					rsp_q.status      <= st_q;
					rsp_q.list_length <= LEN_W'(CMPW'(cnt_next));
					if (kind_q == REQ_READ) begin
						rsp_q.read_data <= (st_q == ST_OK) ? rdata_q : 32'sd1;
					end else begin
						rsp_q.read_data <= '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(cnt_q) <= CMPW'(DEPTH))
		else $error("entry count exceeds store depth");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("item accepted while another is in flight");

	a_cnt_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(state_q) == S_FIN)
		else $error("entry count changed outside result stage");

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_FIN && req.ready)
		else $error("result raised without finishing an item");

endmodule

`default_nettype wire

FILE: test/tb_positional_list_engine.sv
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Drives read, insert, delete and unknown requests into the list engine.
// A short table of requests comes first: the empty list, both value extremes,
// every out-of-range form and the unknown request kind. Random fill, drain
// and mixed bursts follow. Every result is checked field by field against
// the table's expected result or else against a local model of the list.
// Both handshake sides idle at random, except for one long busy stretch.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
	import ple_pkg::*;

	localparam int DEPTH = 16;
	localparam int REQ_COUNT = 650;
	localparam int IDLE_PCT = 38;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   no_idle;

	ple_req_if req_ch();
	ple_rsp_if rsp_ch();

	positional_list_engine #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #4 clk = ~clk;

	logic signed [31:0] list_mem [DEPTH];
	int                 list_len;
	rsp_t               expected_mem [REQ_COUNT];
	int                 wr_idx;
	int                 rd_idx;
	rsp_t               due_rsp;
	dir_row_t           dir_rows [$];
	int errors;
	int n_read, n_insert, n_delete, n_unknown, n_full, n_range, n_checked;

	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		int   i;
		o.read_data = '0;
		o.status = ST_OK;
		case (r.req_type)
			REQ_READ: begin
				if (r.position < list_len) begin
					o.read_data = list_mem[r.position];
				end else begin
					o.read_data = 32'sd1;
					o.status = ST_RANGE;
				end
			end
			REQ_INSERT: begin
				if (r.position > list_len) begin
					o.status = ST_RANGE;
				end else if (list_len >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					for (i = list_len; i > r.position; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[r.position] = r.data_in;
					list_len++;
				end
			end
			REQ_DELETE: begin
				if (list_len == 0) begin
					o.status = ST_OK;
				end else if (r.position >= list_len) begin
					o.status = ST_RANGE;
				end else begin
					for (i = r.position; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			default: begin
				o.status = ST_RANGE;
			end
		endcase
		o.list_length = list_len[LEN_W-1:0];
		return o;
	endfunction

	function automatic void add_row(logic [1:0] kind, logic [POS_W-1:0] pos,
			logic signed [31:0] data, bit typed, logic signed [31:0] rd,
			logic [1:0] st, logic [LEN_W-1:0] len);
		dir_row_t row;
		row.r.req_type = kind;
		row.r.position = pos;
		row.r.data_in = data;
		row.typed = typed;
		row.want.read_data = rd;
		row.want.status = st;
		row.want.list_length = len;
		dir_rows = {dir_rows, row};
	endfunction

	task automatic send_request(input req_t r, input bit typed, input rsp_t want);
		rsp_t predicted;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		predicted = list_apply(r);
		expected_mem[wr_idx] = typed ? want : predicted;
		wr_idx++;
		case (r.req_type)
			REQ_READ:   n_read++;
			REQ_INSERT: n_insert++;
			REQ_DELETE: n_delete++;
			default:    n_unknown++;
		endcase
		if (predicted.status == ST_FULL)
			n_full++;
		if (predicted.status == ST_RANGE)
			n_range++;
	endtask

	task automatic run_random(input int total);
		req_t   r;
		phase_e phase;
		int     burst;
		int     done;
		int     roll;
		int     ins_w;
		int     del_w;
		done = 0;
		while (done < total) begin
			phase = phase_e'($urandom_range(2));
			burst = $urandom_range(40, 8);
			case (phase)
				PH_FILL:  begin ins_w = 70; del_w = 15; end
				PH_DRAIN: begin ins_w = 15; del_w = 70; end
				default:  begin ins_w = 25; del_w = 25; end
			endcase
			while (burst > 0 && done < total) begin
				no_idle <= (done >= 250 && done < 400);
				case ($urandom_range(15))
					0:       r.data_in = 32'sh7fff_ffff;
					1:       r.data_in = 32'sh8000_0000;
					2:       r.data_in = '0;
					3:       r.data_in = -32'sd1;
					default: r.data_in = $urandom();
				endcase
				roll = $urandom_range(99);
				if (roll < 3) begin
					r.req_type = REQ_UNKNOWN;
					r.position = POS_W'($urandom_range(31));
				end else if (roll < 10) begin
					// noise: a read, insert or delete at any position
					r.req_type = 2'($urandom_range(2));
					r.position = POS_W'($urandom_range(31));
				end else begin
					roll = $urandom_range(99);
					if (roll < ins_w)
						r.req_type = REQ_INSERT;
					else if (roll < ins_w + del_w)
						r.req_type = REQ_DELETE;
					else
						r.req_type = REQ_READ;
					if (r.req_type == REQ_INSERT)
						r.position = POS_W'($urandom_range(list_len, 0));
					else
						r.position = (list_len == 0) ? '0 :
							POS_W'($urandom_range(list_len - 1, 0));
				end
				send_request(r, 1'b0, '0);
				done++;
				burst--;
			end
		end
		no_idle <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_checked++;
			if (rd_idx == wr_idx) begin
				errors++;
				$display("%0t: result with nothing expected: %h %0d %0d", $time,
					rsp_ch.data.read_data, rsp_ch.data.status, rsp_ch.data.list_length);
			end else begin
				due_rsp = expected_mem[rd_idx];
				rd_idx++;
				if (rsp_ch.data.read_data !== due_rsp.read_data) begin
					errors++;
					$display("%0t: read_data expected %h, actual %h", $time,
						due_rsp.read_data, rsp_ch.data.read_data);
				end
				if (rsp_ch.data.status !== due_rsp.status) begin
					errors++;
					$display("%0t: status expected %0d, actual %0d", $time,
						due_rsp.status, rsp_ch.data.status);
				end
				if (rsp_ch.data.list_length !== due_rsp.list_length) begin
					errors++;
					$display("%0t: list_length expected %0d, actual %0d", $time,
						due_rsp.list_length, rsp_ch.data.list_length);
				end
			end
		end
		rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		no_idle = 1'b0;
		list_len = 0;
		wr_idx = 0;
		guard = 0;

		add_row(REQ_READ,    5'd0,  32'sd5,         1, 32'sd1,         ST_RANGE, 5'd0);
		add_row(REQ_DELETE,  5'd5,  32'sd0,         1, 32'sd0,         ST_OK,    5'd0);
		add_row(REQ_INSERT,  5'd1,  32'sd9,         1, 32'sd0,         ST_RANGE, 5'd0);
		add_row(REQ_UNKNOWN, 5'd0,  32'sd7,         1, 32'sd0,         ST_RANGE, 5'd0);
		add_row(REQ_INSERT,  5'd0,  32'sh7fff_ffff, 1, 32'sd0,         ST_OK,    5'd1);
		add_row(REQ_INSERT,  5'd0,  32'sh8000_0000, 1, 32'sd0,         ST_OK,    5'd2);
		add_row(REQ_READ,    5'd0,  32'sd0,         1, 32'sh8000_0000, ST_OK,    5'd2);
		add_row(REQ_READ,    5'd1,  32'sd0,         1, 32'sh7fff_ffff, ST_OK,    5'd2);
		add_row(REQ_READ,    5'd31, 32'sd0,         1, 32'sd1,         ST_RANGE, 5'd2);
		add_row(REQ_INSERT,  5'd2,  -32'sd1,        1, 32'sd0,         ST_OK,    5'd3);
		add_row(REQ_INSERT,  5'd1,  32'sd0,         0, '0, ST_OK, '0);
		add_row(REQ_READ,    5'd2,  32'sd0,         0, '0, ST_OK, '0);
		add_row(REQ_DELETE,  5'd3,  32'sd0,         0, '0, ST_OK, '0);
		add_row(REQ_DELETE,  5'd31, 32'sd0,         1, 32'sd0,         ST_RANGE, 5'd3);
		add_row(REQ_INSERT,  5'd31, 32'sd3,         1, 32'sd0,         ST_RANGE, 5'd3);
		add_row(REQ_INSERT,  5'd4,  32'sd4,         1, 32'sd0,         ST_RANGE, 5'd3);
		add_row(REQ_DELETE,  5'd3,  32'sd0,         1, 32'sd0,         ST_RANGE, 5'd3);
		add_row(REQ_DELETE,  5'd0,  32'sd0,         0, '0, ST_OK, '0);
		add_row(REQ_READ,    5'd0,  32'sd0,         0, '0, ST_OK, '0);
		add_row(REQ_READ,    5'd1,  32'sd0,         0, '0, ST_OK, '0);
		add_row(REQ_UNKNOWN, 5'd31, -32'sd1,        1, 32'sd0,         ST_RANGE, 5'd2);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			send_request(dir_rows[k].r, dir_rows[k].typed, dir_rows[k].want);
		run_random(REQ_COUNT - dir_rows.size());
		req_ch.valid <= 1'b0;

		while (rd_idx != wr_idx && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);

		if (rd_idx != wr_idx)
			$display("%0t: %0d results never arrived", $time, wr_idx - rd_idx);
		$display("Sent %0d requests: %0d reads, %0d inserts, %0d deletes, %0d unknown.",
			n_read + n_insert + n_delete + n_unknown, n_read, n_insert, n_delete, n_unknown);
		$display("Checked %0d results; %0d hit a full store, %0d were out of range.",
			n_checked, n_full, n_range);
		if (errors == 0 && rd_idx == wr_idx)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
rtl/ple_pkg.sv
rtl/ple_req_if.sv
rtl/ple_rsp_if.sv
rtl/positional_list_engine.sv
test/tb_positional_list_engine.sv
